// ----- hdl/dvc_pkg.sv -----
// Shared widths, defaults and controller/datapath handshake types for the distinct value counter.
package dvc_pkg;

	localparam int DVC_SAMPLE_W      = 64;
	localparam int DVC_COUNT_W       = 32;
	localparam int DVC_DEPTH_DEFAULT = 64;
	localparam int DVC_OUT_DATA_W    = DVC_SAMPLE_W + DVC_COUNT_W;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;  // a sample beat is taken this cycle
		logic pop;     // move the head entry into the output register
	} dvc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;    // output register can take an entry this cycle
		logic one_left;    // exactly one entry remains to be read out
	} dvc_stat_t;

endpackage

// ----- hdl/dvc_cell.sv -----
// One table entry: holds a value and its count, compares, counts, allocates and shifts.
module dvc_cell
	import dvc_pkg::*;
(
	input  logic                    clk,
	input  logic                    active,
	input  logic                    upd,
	input  logic                    alloc,
	input  logic                    shift,
	input  logic [DVC_SAMPLE_W-1:0] sample,
	input  logic [DVC_SAMPLE_W-1:0] next_value,
	input  logic [DVC_COUNT_W-1:0]  next_count,
	output logic                    hit,
	output logic [DVC_SAMPLE_W-1:0] value,
	output logic [DVC_COUNT_W-1:0]  count
);

	logic [DVC_SAMPLE_W-1:0] value_q;
	logic [DVC_COUNT_W-1:0]  count_q;

	assign hit   = active && (value_q == sample);
	assign value = value_q;
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= next_value;
			count_q <= next_count;
		end else if (upd && hit) begin
			// The count holds once it reaches all ones.
			if (count_q != {DVC_COUNT_W{1'b1}}) begin
				count_q <= count_q + DVC_COUNT_W'(1);
			end
		end else if (alloc) begin
			value_q <= sample;
			count_q <= DVC_COUNT_W'(1);
		end
	end

endmodule

// ----- hdl/dvc_datapath.sv -----
// Datapath: row of table cells, fill count, overflow flag and the output register.
module dvc_datapath
	import dvc_pkg::*;
#(
	parameter int TABLE_DEPTH = DVC_DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dvc_cmd_t                  cmd,
	output dvc_stat_t                 stat,
	input  logic [DVC_SAMPLE_W-1:0]   sample,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [DVC_OUT_DATA_W-1:0] out_data,
	output logic                      out_last,
	output logic                      out_overflow
);

	localparam int UsedW = $clog2(TABLE_DEPTH + 1);

	logic [UsedW-1:0]        used_q;
	logic                    overflow_q;
	logic                    out_valid_q;
	logic [DVC_SAMPLE_W-1:0] out_value_q;
	logic [DVC_COUNT_W-1:0]  out_count_q;
	logic                    out_last_q;
	logic                    out_overflow_q;

	logic [TABLE_DEPTH-1:0]  hits;
	logic [DVC_SAMPLE_W-1:0] cell_value [TABLE_DEPTH];
	logic [DVC_COUNT_W-1:0]  cell_count [TABLE_DEPTH];
	logic                    any_hit;
	logic                    miss;
	logic                    full;

	assign any_hit = |hits;
	assign miss    = cmd.accept && !any_hit;
	assign full    = (used_q == UsedW'(TABLE_DEPTH));

	// Cell 0 is the head of the readout; a pop shifts every entry one place down.
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		logic [DVC_SAMPLE_W-1:0] nv;
		logic [DVC_COUNT_W-1:0]  nc;

		if (k == TABLE_DEPTH - 1) begin : g_top
			assign nv = cell_value[k];
			assign nc = cell_count[k];
		end else begin : g_mid
			assign nv = cell_value[k+1];
			assign nc = cell_count[k+1];
		end

		dvc_cell u_cell (
			.clk        (clk),
			.active     (used_q > UsedW'(k)),
			.upd        (cmd.accept),
			.alloc      (miss && (used_q == UsedW'(k))),
			.shift      (cmd.pop),
			.sample     (sample),
			.next_value (nv),
			.next_count (nc),
			.hit        (hits[k]),
			.value      (cell_value[k]),
			.count      (cell_count[k])
		);
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.one_left = (used_q == UsedW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pop) begin
				used_q <= used_q - UsedW'(1);
				if (stat.one_left) begin
					overflow_q <= 1'b0;
				end
			end else if (miss) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					used_q <= used_q + UsedW'(1);
				end
			end

			if (cmd.pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_value_q    <= cell_value[0];
			out_count_q    <= cell_count[0];
			out_last_q     <= stat.one_left;
			out_overflow_q <= overflow_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = {out_count_q, out_value_q};
	assign out_last     = out_last_q;
	assign out_overflow = out_overflow_q;

endmodule

// ----- hdl/dvc_ctrl.sv -----
// Controller: switches between counting samples and reading the table out.
module dvc_ctrl
	import dvc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  dvc_stat_t stat,
	output dvc_cmd_t  cmd
);

	localparam logic ST_COUNT = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;

	assign in_ready   = (state_q == ST_COUNT);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.pop    = (state_q == ST_DRAIN) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COUNT;
		end else begin
			unique case (state_q)
				ST_COUNT: begin
					if (cmd.accept && in_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cmd.pop && stat.one_left) begin
						state_q <= ST_COUNT;
					end
				end
				default: begin
					state_q <= ST_COUNT;
				end
			endcase
		end
	end

endmodule

// ----- hdl/distinct_value_counter_core.sv -----
// Top level of the distinct value counter: controller plus datapath.
//
//   channel  dir  tdata                                  tlast         tuser
//   s_       in   sample[63:0]                           end_of_batch  -
//   m_       out  distinct_value[63:0], occurrences[95:64] last_entry  overflowed
//
// Each sample is compared against every used entry at once: the matching entry
// counts up, or else the next free entry is filled; when the table is full a new
// value is dropped and the overflow flag is set. After the beat marked tlast the
// input stalls while the table drains, one entry per cycle through the output
// register while m_tready is high. Reset empties the table and clears the
// overflow flag at once; there is no clearing pass.
module distinct_value_counter_core
	import dvc_pkg::*;
#(
	parameter int TABLE_DEPTH = DVC_DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [DVC_SAMPLE_W-1:0]   s_tdata,   // sample
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [DVC_OUT_DATA_W-1:0] m_tdata,   // distinct_value, occurrences
	output logic                      m_tlast,
	output logic                      m_tuser    // overflowed
);

	dvc_cmd_t  cmd;
	dvc_stat_t stat;

	dvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dvc_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (s_tdata),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_data     (m_tdata),
		.out_last     (m_tlast),
		.out_overflow (m_tuser)
	);

endmodule

// ----- tb/distinct_value_counter_core_tb.sv -----
// Testbench for distinct_value_counter_core: directed and random batches against a histogram scoreboard.
`timescale 1ns / 100ps

module distinct_value_counter_core_tb;
	import dvc_pkg::*;

	localparam int DEPTH        = DVC_DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = DEPTH + 20;

	typedef logic signed [DVC_SAMPLE_W-1:0] sample_t;
	typedef logic [DVC_COUNT_W-1:0] count_t;

	typedef struct {
		sample_t value;
		count_t  count;
		bit      last;
		bit      ovf;
	} hist_entry_t;

	// Keeps its own copy of the value table and checks every readout beat in order.
	class histogram_scoreboard;
		sample_t     values [DEPTH];
		count_t      counts [DEPTH];
		int unsigned used;
		bit          ovf;
		hist_entry_t expected_entries [$];
		int unsigned failures;

		function new();
			used = 0;
			ovf = 0;
			failures = 0;
		endfunction

		function int unsigned pending();
			return expected_entries.size();
		endfunction

		task report(input string msg);
			failures++;
			$display("%0t mismatch: %s", $realtime, msg);
		endtask

		function void note_sample(input sample_t v, input bit eob);
			bit          hit;
			hist_entry_t e;
			hit = 0;
			for (int k = 0; k < used; k++) begin
				if (!hit && values[k] == v) begin
					hit = 1;
					if (counts[k] != '1)
						counts[k] = counts[k] + count_t'(1);
				end
			end
			if (!hit) begin
				if (used < DEPTH) begin
					values[used] = v;
					counts[used] = count_t'(1);
					used++;
				end else begin
					ovf = 1;
				end
			end
			if (eob) begin
				for (int k = 0; k < used; k++) begin
					e.value = values[k];
					e.count = counts[k];
					e.last  = (k == used - 1);
					e.ovf   = ovf;
					expected_entries.push_back(e);
				end
				used = 0;
				ovf = 0;
			end
		endfunction

		task check_entry(input sample_t value, input count_t count, input bit last, input bit flag);
			hist_entry_t e;
			if (expected_entries.size() == 0) begin
				report($sformatf("unexpected beat value=%0d count=%0d", value, count));
			end else begin
				e = expected_entries.pop_front();
				if (value !== e.value || count !== e.count || last !== e.last || flag !== e.ovf)
					report($sformatf("got value=%0d count=%0d last=%0b ovf=%0b, want %0d %0d %0b %0b",
						value, count, last, flag, e.value, e.count, e.last, e.ovf));
			end
		endtask
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [DVC_SAMPLE_W-1:0]   s_tdata;
	logic                      s_tlast;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [DVC_OUT_DATA_W-1:0] m_tdata;
	logic                      m_tlast;
	logic                      m_tuser;

	histogram_scoreboard sb = new();

	bit          tx_steady;
	bit          rx_steady;
	int unsigned items_sent;
	int unsigned idle_cycles;
	sample_t     batch_q [$];

	distinct_value_counter_core #(
		.TABLE_DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap(input bit steady);
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sample_t wide_value();
		return {$urandom, $urandom};
	endfunction

	function automatic sample_t rand_value();
		if ($urandom_range(0, 9) != 0)
			return wide_value();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(DVC_SAMPLE_W-1){1'b0}}};
			3: return {1'b0, {(DVC_SAMPLE_W-1){1'b1}}};
			default: return sample_t'(1);
		endcase
	endfunction

	task send_sample(input sample_t v, input bit eob);
		int unsigned gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= wide_value();
			s_tlast  <= 1'($urandom_range(0, 1));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= eob;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(v, eob);
		items_sent++;
	endtask

	task send_batch();
		foreach (batch_q[k])
			send_sample(batch_q[k], k == batch_q.size() - 1);
	endtask

	// The last beat is already taken, so valid drops before the input opens again.
	task wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Receiver: alternating ready runs and stalls.
	initial begin
		int unsigned stall;
		int unsigned run;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_gap(rx_steady);
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			run = $urandom_range(1, 8);
			repeat (run - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_entry(m_tdata[DVC_SAMPLE_W-1:0], m_tdata[DVC_OUT_DATA_W-1:DVC_SAMPLE_W],
				m_tlast, m_tuser);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t watchdog: no beat for %0d cycles", $realtime, IDLE_LIMIT);
			$display("FAIL distinct_value_counter_core");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		sample_t     pool [$];
		int unsigned len;
		int unsigned npool;
		int unsigned kind;
		int unsigned batch_idx;

		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		tx_steady   = 1'b0;
		rx_steady   = 1'b0;
		items_sent  = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single-sample batches at both ends of the signed range.
		batch_q = '{{1'b1, {(DVC_SAMPLE_W-1){1'b0}}}};
		send_batch();
		batch_q = '{{1'b0, {(DVC_SAMPLE_W-1){1'b1}}}};
		send_batch();
		// Repeats mixed with new values, zero and minus one.
		batch_q = '{0, -1, 0, 0, -1, 1};
		send_batch();
		// Final sample matches an earlier entry, so the last mark lands on another one.
		batch_q = '{5, 7, 5};
		send_batch();
		batch_q = '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
		send_batch();
		// Values differing only in the sign bit are distinct.
		batch_q = '{64'h8000_0000_0000_0001, 64'h0000_0000_0000_0001};
		send_batch();
		wait_drained();

		batch_idx = 0;
		while (items_sent < RANDOM_ITEMS + 16) begin
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			batch_q.delete();
			pool.delete();
			if (batch_idx % 8 == 3 || kind >= 92) begin
				// Fill the table close to, to or past its depth; new values beyond the depth are dropped.
				npool = $urandom_range(DEPTH - 4, DEPTH + 6);
				len = $urandom_range(npool, npool + 16);
				repeat (npool) pool.push_back(wide_value());
				foreach (pool[k])
					batch_q.push_back(pool[k]);
				repeat (len - npool) batch_q.push_back(pool[$urandom_range(0, npool - 1)]);
			end else begin
				len = (kind < 75) ? $urandom_range(1, 12) : $urandom_range(13, 40);
				npool = $urandom_range(1, len);
				repeat (npool) pool.push_back(rand_value());
				repeat (len) batch_q.push_back(pool[$urandom_range(0, npool - 1)]);
			end
			send_batch();
			if (batch_idx % 6 == 5)
				wait_drained();
			batch_idx++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("PASS distinct_value_counter_core");
		end else begin
			$display("FAIL distinct_value_counter_core");
		end
		$finish;
	end

endmodule
